FILE: rtl/hfw_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap footprint walkability package
// Item, result and state types plus register indexes shared by the core,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hfw_pkg;

	localparam int H_W       = 8;
	localparam int FP_W      = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WATER_LEVEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOOTPRINT_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOOTPRINT_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOPE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WATER_SLOPE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WATER_DEPTH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WATER_DEPTH = 3'd6;

	typedef struct packed {
		logic           opcode;
		logic [H_W-1:0] cell_x;
		logic [H_W-1:0] cell_y;
		logic [H_W-1:0] height_value;
	} item_t;

	typedef struct packed {
		logic walkable;
		logic too_steep;
		logic depth_out_of_range;
		logic under_water;
		logic out_of_bounds;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/hfw_if.sv
// ----------------------------------------------------------------------------
// Heightmap footprint walkability channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfw_item_if import hfw_pkg::*;;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hfw_result_if import hfw_pkg::*;;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hfw_cfg_if import hfw_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [H_W-1:0]       wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/heightmap_footprint_walkability_core.sv
// ----------------------------------------------------------------------------
// Heightmap footprint walkability core
// Holds a byte heightmap in one synchronous RAM and checks footprint slope,
// water depth and water contact for query items.
// ----------------------------------------------------------------------------
// Write item: accepted in idle, next item taken in the following cycle.
// Query leaving the map: the finish state registers the result, then idle again.
// Query on the map: scan reads the (fx+1)*(fz+1) footprint cells, one RAM read
// per cycle, then drain and finish; finish registers the result and returns to
// idle for the next item. A waiting result stalls a query in finish. Reset clears
// control and loads register defaults; the heightmap holds undefined data until written.
`default_nettype none

module heightmap_footprint_walkability_core import hfw_pkg::*; #(
	parameter int MAP_WIDTH     = 256,
	parameter int MAP_HEIGHT    = 256,
	parameter int MAX_FOOTPRINT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	hfw_cfg_if.sink       cfg,
	hfw_item_if.sink      items,
	hfw_result_if.source  results
);

	localparam int DEPTH    = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW       = $clog2(DEPTH);
	localparam int LINE_LEN = MAX_FOOTPRINT + 1;
	localparam int LW       = $clog2(LINE_LEN);
	localparam int CW       = 14;

	logic [H_W-1:0]  water_level_q;
	logic [FP_W-1:0] footprint_x_q;
	logic [FP_W-1:0] footprint_z_q;
	logic [H_W-1:0]  max_slope_q;
	logic [H_W-1:0]  max_water_slope_q;
	logic [H_W-1:0]  min_water_depth_q;
	logic [H_W-1:0]  max_water_depth_q;

	state_t state_q, state_d;

	logic [H_W-1:0] mem [DEPTH];
	logic [H_W-1:0] rd_data_s1;
	logic           rd_v_s1;
	logic [FP_W-1:0] dx_s1, dy_s1;

	logic [AW-1:0]   addr_q;
	logic [FP_W-1:0] dx_q, dy_q;
	logic            wet_q, depth_bad_q, oob_q;
	logic [H_W-1:0]  slope_max_q;
	logic [H_W-1:0]  line_q [LINE_LEN];
	logic [H_W-1:0]  up_q;

	logic            out_valid_q;
	result_t         res_q;

	logic [FP_W-1:0] fx, fz;
	logic            in_xfer, out_xfer, load_out, last_rd;
	logic            is_query, oob, wr_in_map, mem_we;
	logic [AW-1:0]   item_addr, row_step;
	logic [H_W-1:0]  h_left, h_up, h_diag, hi_a, hi_b, lo_a, lo_b, hi, lo, slope;
	logic [H_W-1:0]  depth, limit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_level_q     <= '0;
			footprint_x_q     <= FP_W'(1);
			footprint_z_q     <= FP_W'(1);
			max_slope_q       <= '1;
			max_water_slope_q <= '1;
			min_water_depth_q <= '0;
			max_water_depth_q <= '1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_WATER_LEVEL:     water_level_q     <= cfg.wdata;
				REG_FOOTPRINT_X:     footprint_x_q     <= cfg.wdata[FP_W-1:0];
				REG_FOOTPRINT_Z:     footprint_z_q     <= cfg.wdata[FP_W-1:0];
				REG_MAX_SLOPE:       max_slope_q       <= cfg.wdata;
				REG_MAX_WATER_SLOPE: max_water_slope_q <= cfg.wdata;
				REG_MIN_WATER_DEPTH: min_water_depth_q <= cfg.wdata;
				REG_MAX_WATER_DEPTH: max_water_depth_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign fx = (int'(footprint_x_q) > MAX_FOOTPRINT) ? FP_W'(MAX_FOOTPRINT) : footprint_x_q;
	assign fz = (int'(footprint_z_q) > MAX_FOOTPRINT) ? FP_W'(MAX_FOOTPRINT) : footprint_z_q;

	assign in_xfer  = items.valid && items.ready;
	assign out_xfer = results.valid && results.ready;
	assign is_query = (items.data.opcode == OP_QUERY);
	assign oob      = (CW'(items.data.cell_x) + CW'(fx) >= CW'(MAP_WIDTH)) ||
	                  (CW'(items.data.cell_y) + CW'(fz) >= CW'(MAP_HEIGHT));
	assign wr_in_map = (CW'(items.data.cell_x) < CW'(MAP_WIDTH)) &&
	                   (CW'(items.data.cell_y) < CW'(MAP_HEIGHT));
	assign item_addr = AW'(32'(items.data.cell_y) * 32'(MAP_WIDTH) +
	                       32'(items.data.cell_x));
	assign row_step  = AW'(MAP_WIDTH) - AW'(fx);
	assign last_rd   = (dx_q == fx) && (dy_q == fz);
	assign mem_we    = in_xfer && !is_query && wr_in_map;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		items.ready = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				items.ready = 1'b1;
				if (in_xfer && is_query) begin
					state_d = oob ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				load_out = !out_valid_q || results.ready;
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[item_addr] <= items.data.height_value;
		end
		if (state_q == ST_SCAN) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	// 2x2 window: current sample, left neighbor, row above, diagonal
	assign h_left = line_q[0];
	assign h_up   = line_q[LW'(fx)];
	assign h_diag = up_q;
	assign hi_a   = (rd_data_s1 > h_left) ? rd_data_s1 : h_left;
	assign hi_b   = (h_up > h_diag) ? h_up : h_diag;
	assign lo_a   = (rd_data_s1 < h_left) ? rd_data_s1 : h_left;
	assign lo_b   = (h_up < h_diag) ? h_up : h_diag;
	assign hi     = (hi_a > hi_b) ? hi_a : hi_b;
	assign lo     = (lo_a < lo_b) ? lo_a : lo_b;
	assign slope  = hi - lo;
	assign depth  = (h_diag < water_level_q) ? (water_level_q - h_diag) : '0;
	assign limit  = wet_q ? max_water_slope_q : max_slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= dx_q;
		dy_s1 <= dy_q;
		if (in_xfer && is_query) begin
			addr_q      <= item_addr;
			dx_q        <= '0;
			dy_q        <= '0;
			wet_q       <= 1'b0;
			depth_bad_q <= 1'b0;
			slope_max_q <= '0;
			oob_q       <= oob;
		end else if (state_q == ST_SCAN) begin
			if (dx_q == fx) begin
				dx_q   <= '0;
				dy_q   <= dy_q + FP_W'(1);
				addr_q <= addr_q + row_step;
			end else begin
				dx_q   <= dx_q + FP_W'(1);
				addr_q <= addr_q + AW'(1);
			end
		end
		if (rd_v_s1) begin
			if (rd_data_s1 < water_level_q) begin
				wet_q <= 1'b1;
			end
			if ((dx_s1 != '0) && (dy_s1 != '0)) begin
				if (slope > slope_max_q) begin
					slope_max_q <= slope;
				end
				if ((depth < min_water_depth_q) || (depth > max_water_depth_q)) begin
					depth_bad_q <= 1'b1;
				end
			end
			up_q      <= h_up;
			line_q[0] <= rd_data_s1;
			for (int k = 1; k < LINE_LEN; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
		if (load_out) begin
			res_q.too_steep          <= !oob_q && (slope_max_q > limit);
			res_q.depth_out_of_range <= !oob_q && depth_bad_q;
			res_q.under_water        <= !oob_q && wet_q;
			res_q.out_of_bounds      <= oob_q;
			res_q.walkable           <= !oob_q && !(slope_max_q > limit) && !depth_bad_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = res_q;

endmodule

`default_nettype wire

FILE: rtl/hfw_checker.sv
// ----------------------------------------------------------------------------
// Heightmap footprint walkability checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module hfw_checker import hfw_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result changed while stalled");

	a_walk_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.walkable ==
			(!res_data.too_steep && !res_data.depth_out_of_range && !res_data.out_of_bounds)))
		else $error("walkable disagrees with failure flags");

	a_oob_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.out_of_bounds |->
			!res_data.under_water && !res_data.too_steep && !res_data.depth_out_of_range)
		else $error("out of bounds result carries other flags");

endmodule

bind heightmap_footprint_walkability_core hfw_checker u_hfw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.res_data (results.data)
);

`default_nettype wire

FILE: bench/hfw_tb_pkg.sv
// ----------------------------------------------------------------------------
// Walkability scoreboard
// Mirrors the heightmap and register file, predicts the verdict of every
// accepted query and checks returned verdicts in order.
// ----------------------------------------------------------------------------
package hfw_tb_pkg;

	import hfw_pkg::*;

	localparam int GRID_W           = 256;
	localparam int GRID_H           = 256;
	localparam int FP_MAX           = 16;
	localparam int SHOWN_MISMATCHES = 10;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	class walkability_scoreboard;

		bit [H_W-1:0] height_map [GRID_W*GRID_H];
		int unsigned  water_level;
		int unsigned  footprint_x;
		int unsigned  footprint_z;
		int unsigned  max_slope;
		int unsigned  max_water_slope;
		int unsigned  min_water_depth;
		int unsigned  max_water_depth;
		result_t      pending_verdicts[$];
		int unsigned  mismatches;

		function new();
			water_level     = 0;
			footprint_x     = 1;
			footprint_z     = 1;
			max_slope       = 255;
			max_water_slope = 255;
			min_water_depth = 0;
			max_water_depth = 255;
			mismatches      = 0;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] index, logic [H_W-1:0] wdata);
			case (index)
				REG_WATER_LEVEL:     water_level     = wdata;
				REG_FOOTPRINT_X:     footprint_x     = wdata[FP_W-1:0];
				REG_FOOTPRINT_Z:     footprint_z     = wdata[FP_W-1:0];
				REG_MAX_SLOPE:       max_slope       = wdata;
				REG_MAX_WATER_SLOPE: max_water_slope = wdata;
				REG_MIN_WATER_DEPTH: min_water_depth = wdata;
				REG_MAX_WATER_DEPTH: max_water_depth = wdata;
				default: ;
			endcase
		endfunction

		function int unsigned span_x();
			return (footprint_x > FP_MAX) ? FP_MAX : footprint_x;
		endfunction

		function int unsigned span_z();
			return (footprint_z > FP_MAX) ? FP_MAX : footprint_z;
		endfunction

		function int unsigned height_at(int unsigned x, int unsigned y);
			return height_map[y*GRID_W + x];
		endfunction

		function result_t predict_verdict(item_t it);
			int unsigned fx, fz, x, y, dx, dy, h, lo, hi, depth, limit;
			bit          wet, steep, depth_bad;
			result_t     r;
			fx = span_x();
			fz = span_z();
			x  = it.cell_x;
			y  = it.cell_y;
			r  = '0;
			if (x + fx >= GRID_W || y + fz >= GRID_H) begin
				r.out_of_bounds = 1'b1;
				return r;
			end
			wet       = 1'b0;
			steep     = 1'b0;
			depth_bad = 1'b0;
			for (dy = 0; dy <= fz; dy++)
				for (dx = 0; dx <= fx; dx++)
					if (height_at(x + dx, y + dy) < water_level)
						wet = 1'b1;
			limit = wet ? max_water_slope : max_slope;
			for (dy = 0; dy < fz; dy++) begin
				for (dx = 0; dx < fx; dx++) begin
					h     = height_at(x + dx, y + dy);
					depth = (h < water_level) ? water_level - h : 0;
					lo    = h;
					hi    = h;
					for (int unsigned k = 1; k < 4; k++) begin
						h  = height_at(x + dx + (k & 1), y + dy + (k >> 1));
						lo = (h < lo) ? h : lo;
						hi = (h > hi) ? h : hi;
					end
					if (hi - lo > limit)
						steep = 1'b1;
					if (depth < min_water_depth || depth > max_water_depth)
						depth_bad = 1'b1;
				end
			end
			r.walkable           = !steep && !depth_bad;
			r.too_steep          = steep;
			r.depth_out_of_range = depth_bad;
			r.under_water        = wet;
			return r;
		endfunction

		function void note_item(item_t it);
			if (it.opcode == OP_WRITE)
				height_map[{it.cell_y, it.cell_x}] = it.height_value;
			else
				pending_verdicts.push_back(predict_verdict(it));
		endfunction

		function void check_verdict(result_t got);
			result_t want;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected verdict transfer: got %b", got);
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.walkable !== want.walkable || got.too_steep !== want.too_steep ||
			    got.depth_out_of_range !== want.depth_out_of_range ||
			    got.under_water !== want.under_water ||
			    got.out_of_bounds !== want.out_of_bounds) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("verdict mismatch: walk/steep/depth/wet/oob expected %b%b%b%b%b got %b%b%b%b%b",
					         want.walkable, want.too_steep, want.depth_out_of_range,
					         want.under_water, want.out_of_bounds,
					         got.walkable, got.too_steep, got.depth_out_of_range,
					         got.under_water, got.out_of_bounds);
			end
		endfunction

	endclass

endpackage

FILE: bench/heightmap_footprint_walkability_core_tb.sv
// ----------------------------------------------------------------------------
// Heightmap footprint walkability core testbench
// Fills the heightmap lazily around a few anchor points so that no query ever
// reads an unwritten cell, then runs directed and random query phases under
// several register settings and idling patterns, checking every verdict.
// ----------------------------------------------------------------------------
module heightmap_footprint_walkability_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import hfw_pkg::*;
	import hfw_tb_pkg::*;

	localparam int LIMIT_CYCLES   = 1_500_000;
	localparam int NUM_PHASES     = 12;
	localparam int PHASE_ITEMS    = 72;
	localparam int PRESSURE_PHASE = 7;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 300;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;

	hfw_cfg_if    cfg_ch ();
	hfw_item_if   item_ch ();
	hfw_result_if result_ch ();

	heightmap_footprint_walkability_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (item_ch),
		.results (result_ch)
	);

	walkability_scoreboard tracker;
	bit                    cell_known [GRID_W*GRID_H];
	idle_mode_t            idle_mode    = IDLE_NONE;
	int unsigned           hold_request = 0;
	int unsigned           hold_left    = 0;
	int unsigned           cycle_count  = 0;
	int unsigned           items_sent   = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function bit idle_roll(bit sender_side);
		case (idle_mode)
			IDLE_SENDER:   return sender_side && ($urandom_range(0, 99) < 64);
			IDLE_RECEIVER: return !sender_side && ($urandom_range(0, 99) < 64);
			IDLE_BOTH:     return $urandom_range(0, 99) < 7;
			default:       return 1'b0;
		endcase
	endfunction

	// verdict side: long hold-offs are counted here
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			tracker.check_verdict(result_ch.data);
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= !idle_roll(1'b0);
		end
	end

	task automatic send_item(item_t it);
		while (idle_roll(1'b1)) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
		tracker.note_item(it);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [H_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.apply_reg(idx, val);
	endtask

	task automatic write_one_reg(logic [CFG_IDX_W-1:0] idx, logic [H_W-1:0] val);
		write_reg(idx, val);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic settle(int unsigned extra);
		item_ch.valid <= 1'b0;
		while (tracker.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	function int unsigned pick_height();
		int v;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 255);
		v = int'(tracker.water_level) + int'($urandom_range(0, 24)) - 12;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v;
	endfunction

	task automatic put_height(int unsigned x, int unsigned y, int unsigned h);
		item_t it;
		it.opcode       = OP_WRITE;
		it.cell_x       = x[H_W-1:0];
		it.cell_y       = y[H_W-1:0];
		it.height_value = h[H_W-1:0];
		send_item(it);
		cell_known[y*GRID_W + x] = 1'b1;
	endtask

	// writes any cell of the enlarged footprint not yet known, then queries
	task automatic ask(int unsigned x, int unsigned y);
		int unsigned fx, fz, dx, dy;
		item_t       it;
		fx = tracker.span_x();
		fz = tracker.span_z();
		if (x + fx < GRID_W && y + fz < GRID_H)
			for (dy = 0; dy <= fz; dy++)
				for (dx = 0; dx <= fx; dx++)
					if (!cell_known[(y + dy)*GRID_W + x + dx])
						put_height(x + dx, y + dy, pick_height());
		it.opcode       = OP_QUERY;
		it.cell_x       = x[H_W-1:0];
		it.cell_y       = y[H_W-1:0];
		it.height_value = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	task automatic configure(int p);
		int unsigned wl, fx, fz, ms, mws, mind, maxd;
		wl   = $urandom_range(0, 255);
		fx   = $urandom_range(1, 4);
		fz   = $urandom_range(1, 4);
		ms   = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 48);
		mws  = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 48);
		mind = $urandom_range(0, 4);
		maxd = $urandom_range(3, 24);
		case (p)
			0: begin
				wl = 128;
				fx = 2;
				fz = 2;
			end
			1: begin
				wl   = 255;
				fx   = 1;
				fz   = 3;
				ms   = 0;
				mws  = 0;
				mind = 0;
				maxd = 255;
			end
			2: begin
				wl   = 0;
				fx   = 3;
				fz   = 1;
				ms   = 255;
				mws  = 255;
				mind = 0;
				maxd = 0;
			end
			3: begin
				fx = 0;
				fz = 0;
			end
			4: begin
				fx = 16;
				fz = 16;
				ms = $urandom_range(20, 255);
			end
			5: begin
				fx = 31;
				fz = 17;
			end
			6: begin
				wl   = 255;
				fx   = 0;
				fz   = 4;
				mind = 255;
				maxd = 255;
			end
			PRESSURE_PHASE: begin
				fx = 1;
				fz = 1;
			end
			default: ;
		endcase
		write_reg(REG_WATER_LEVEL, 8'(wl));
		write_reg(REG_FOOTPRINT_X, {3'($urandom_range(0, 7)), 5'(fx)});
		write_reg(REG_FOOTPRINT_Z, {3'($urandom_range(0, 7)), 5'(fz)});
		write_reg(REG_MAX_SLOPE, 8'(ms));
		write_reg(REG_MAX_WATER_SLOPE, 8'(mws));
		write_reg(REG_MIN_WATER_DEPTH, 8'(mind));
		write_reg(REG_MAX_WATER_DEPTH, 8'(maxd));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(int p);
		int unsigned fx, fz, spread, ax, ay, roll, start;
		fx     = tracker.span_x();
		fz     = tracker.span_z();
		spread = (fx > 8 || fz > 8) ? 1 : 4;
		case (p % 4)
			0: begin
				ax = 0;
				ay = 0;
			end
			1: begin
				ax = 255 - fx - spread;
				ay = 255 - fz - spread;
			end
			2: begin
				ax = 100;
				ay = 37;
			end
			default: begin
				ax = 0;
				ay = 255 - fz - spread;
			end
		endcase
		if (spread == 1) begin
			ax = 0;
			ay = 0;
		end
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				ask(ax + $urandom_range(0, spread), ay + $urandom_range(0, spread));
			end else if (roll < 55) begin
				if (fx == 0 && fz == 0)
					ask(ax, ay);
				else if (fz == 0 || (fx != 0 && $urandom_range(0, 1) == 1))
					ask($urandom_range(256 - fx, 255), $urandom_range(0, 255));
				else
					ask($urandom_range(0, 255), $urandom_range(256 - fz, 255));
			end else if (roll < 85) begin
				put_height(ax + $urandom_range(0, spread + fx), ay + $urandom_range(0, spread + fz),
				           pick_height());
			end else if (roll < 95) begin
				put_height($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			end else if (fx <= 2 && fz <= 2) begin
				ask($urandom_range(0, 255 - fx), $urandom_range(0, 255 - fz));
			end else begin
				ask(ax, ay);
			end
		end
	endtask

	initial begin
		tracker = new();
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.data    <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= '0;
		cfg_ch.wdata    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1x1 footprint, dry, widest limits
		put_height(0, 0, 0);
		put_height(1, 0, 255);
		put_height(0, 1, 255);
		put_height(1, 1, 0);
		ask(0, 0);
		put_height(254, 254, 7);
		put_height(255, 254, 0);
		put_height(254, 255, 255);
		put_height(255, 255, 7);
		ask(254, 254);
		ask(255, 9);
		ask(9, 255);
		ask(255, 255);
		settle(SETTLE_CYCLES);
		write_one_reg(REG_UNMAPPED, 8'hFF);
		ask(0, 0);
		settle(SETTLE_CYCLES);
		write_one_reg(REG_MAX_SLOPE, 8'd254);
		ask(0, 0);
		settle(SETTLE_CYCLES);
		write_one_reg(REG_WATER_LEVEL, 8'd1);
		ask(0, 0);
		ask(254, 254);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle(SETTLE_CYCLES);
			configure(p);
			idle_mode = idle_mode_t'(p % 4);
			if (p == PRESSURE_PHASE)
				hold_request = HOLD_CYCLES;
			run_phase(p);
		end
		settle(DRAIN_CYCLES);

		if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
